// ----- hdl/aos_pkg.sv -----
// ----------------------------------------------------------------------------
// aos_pkg
// Shared types and constants for the audio onset slicer.
// ----------------------------------------------------------------------------
package aos_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned MAG_W       = SAMPLE_W + 1;
  localparam int unsigned THR_W       = 15;
  localparam int unsigned REFR_W      = 20;
  localparam int unsigned CHAN_W      = 4;
  localparam int unsigned CFG_DATA_W  = 20;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned FRAME_OUT_W = 32;
  localparam int unsigned POINTS_W    = 13;
  localparam int unsigned LANES_MAX   = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_REFRACTORY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHANNELS   = 2'd2;

  // configuration reset values
  localparam logic [THR_W-1:0]  THRESHOLD_RST  = 15'd4096;
  localparam logic [REFR_W-1:0] REFRACTORY_RST = 20'd240;
  localparam logic [CHAN_W-1:0] CHANNELS_RST   = 4'd2;

  typedef struct packed {
    logic                       first_frame;
    logic signed [SAMPLE_W-1:0] sample_0;
    logic signed [SAMPLE_W-1:0] sample_1;
    logic signed [SAMPLE_W-1:0] sample_2;
    logic signed [SAMPLE_W-1:0] sample_3;
    logic signed [SAMPLE_W-1:0] sample_4;
    logic signed [SAMPLE_W-1:0] sample_5;
    logic signed [SAMPLE_W-1:0] sample_6;
    logic signed [SAMPLE_W-1:0] sample_7;
  } aos_in_t;

  typedef struct packed {
    logic                   onset;
    logic [FRAME_OUT_W-1:0] onset_frame;
    logic [POINTS_W-1:0]    points_so_far;
    logic                   overflow;
  } aos_out_t;

  // control passed from the handshake logic to the tracker
  typedef struct packed {
    logic load;
    logic first_frame;
  } aos_step_t;

endpackage

// ----- hdl/audio_onset_slicer_core.sv -----
// ----------------------------------------------------------------------------
// audio_onset_slicer_core
// Threshold onset detector with refractory interval, one result per frame.
// ----------------------------------------------------------------------------
//
//  channel | ports                          | beat
//  --------+--------------------------------+------------------------------
//  in      | in_valid, in_stall, in_beat    | one frame: first_frame, 8 samples
//  out     | out_valid, out_stall, out_beat | onset, frame index, count, ovf
//  cfg     | cfg_we, cfg_index, cfg_wdata   | register write, no read-back
//
//  One frame per cycle sustained while out_stall is low; an input beat reaches
//  the result beat through the lane register, then the tracker/result register.
//  The state loop in the tracker (32-bit gap subtract and compare) sets the
//  per-frame rate.
//  rst_n is synchronous; it clears config to defaults and all clip state.
//  A stalled result holds in the output register while the lane stage still
//  takes a new frame; in_stall rises only when both stages are full.
// ----------------------------------------------------------------------------
module audio_onset_slicer_core
  import aos_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 8,
  parameter int unsigned MAX_POINTS   = 4096,
  parameter int unsigned FRAME_BITS   = 32
)
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  aos_in_t               in_beat,

  output logic                  out_valid,
  input  logic                  out_stall,
  output aos_out_t              out_beat,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [THR_W-1:0]  threshold_r;
  logic [REFR_W-1:0] refractory_r;
  logic [CHAN_W-1:0] channels_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= THRESHOLD_RST;
      refractory_r <= REFRACTORY_RST;
      channels_r   <= CHANNELS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_THRESHOLD:  threshold_r  <= cfg_wdata[THR_W-1:0];
        CFG_IDX_REFRACTORY: refractory_r <= cfg_wdata[REFR_W-1:0];
        CFG_IDX_CHANNELS:   channels_r   <= cfg_wdata[CHAN_W-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // channel count clamped to 1..MAX_CHANNELS
  logic [CHAN_W-1:0] chan_eff;

  always_comb begin
    if (channels_r == '0) begin
      chan_eff = CHAN_W'(1);
    end else if (channels_r > CHAN_W'(MAX_CHANNELS)) begin
      chan_eff = CHAN_W'(MAX_CHANNELS);
    end else begin
      chan_eff = channels_r;
    end
  end

  // handshake: two stages, each loads when empty or when it drains
  logic s1_valid_r, s1_valid_nxt;
  logic s1_first_r;
  logic out_valid_r, out_valid_nxt;
  logic out_load, s1_load, in_acc;

  assign out_load      = !out_valid_r || !out_stall;
  assign s1_load       = !s1_valid_r || out_load;
  assign in_stall      = !s1_load;
  assign in_acc        = in_valid && s1_load;
  assign s1_valid_nxt  = s1_load ? in_valid : s1_valid_r;
  assign out_valid_nxt = out_load ? s1_valid_r : out_valid_r;
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_first_r <= in_beat.first_frame;
    end
  end

  // lanes: one magnitude unit per channel
  logic [LANES_MAX-1:0][SAMPLE_W-1:0] samples;
  logic [MAX_CHANNELS-1:0][MAG_W-1:0] mags;

  assign samples = {in_beat.sample_7, in_beat.sample_6, in_beat.sample_5,
                    in_beat.sample_4, in_beat.sample_3, in_beat.sample_2,
                    in_beat.sample_1, in_beat.sample_0};

  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
    aos_lane u_lane (
      .clk    (clk),
      .load   (in_acc),
      .in_use (CHAN_W'(i) < chan_eff),
      .sample (samples[i]),
      .mag_r  (mags[i])
    );
  end

  // merge: frame peak against threshold
  logic above;

  aos_merge #(
    .LANES (MAX_CHANNELS)
  ) u_merge (
    .mags      (mags),
    .threshold (threshold_r),
    .above     (above)
  );

  // clip state and result register
  aos_step_t step;

  assign step.load        = out_load && s1_valid_r;
  assign step.first_frame = s1_first_r;

  aos_track #(
    .FRAME_BITS (FRAME_BITS),
    .MAX_POINTS (MAX_POINTS)
  ) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .above      (above),
    .refractory (refractory_r),
    .out_r      (out_beat)
  );

endmodule

// ----- hdl/aos_lane.sv -----
// ----------------------------------------------------------------------------
// aos_lane
// One channel lane: absolute value of a PCM16 sample, gated by channel use,
// registered.
// ----------------------------------------------------------------------------
module aos_lane
  import aos_pkg::*;
(
  input  logic                       clk,
  input  logic                       load,
  input  logic                       in_use,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic [MAG_W-1:0]           mag_r
);

  logic [MAG_W-1:0] raw;
  logic [MAG_W-1:0] mag_nxt;

  assign raw = {1'b0, sample};

  // -32768 comes out as 32768, hence the extra bit
  always_comb begin
    if (!in_use) begin
      mag_nxt = '0;
    end else if (sample[SAMPLE_W-1]) begin
      mag_nxt = (MAG_W'(1) << SAMPLE_W) - raw;
    end else begin
      mag_nxt = raw;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mag_r <= mag_nxt;
    end
  end

endmodule

// ----- hdl/aos_merge.sv -----
// ----------------------------------------------------------------------------
// aos_merge
// Compares every lane magnitude against the threshold and ORs the hits; the
// frame peak reaches the threshold exactly when one lane does.
// ----------------------------------------------------------------------------
module aos_merge
  import aos_pkg::*;
#(
  parameter int unsigned LANES = 8
)
(
  input  logic [LANES-1:0][MAG_W-1:0] mags,
  input  logic [THR_W-1:0]            threshold,
  output logic                        above
);

  // lanes not in use hold zero, so they only hit at threshold zero
  always_comb begin
    above = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      above = above | (mags[i] >= MAG_W'(threshold));
    end
  end

endmodule

// ----- hdl/aos_track.sv -----
// ----------------------------------------------------------------------------
// aos_track
// Per-clip state: rising-edge detect, refractory spacing, onset count limit,
// saturating frame counter. Also holds the result register.
// ----------------------------------------------------------------------------
module aos_track
  import aos_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 32,
  parameter int unsigned MAX_POINTS = 4096
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  aos_step_t         step,
  input  logic              above,
  input  logic [REFR_W-1:0] refractory,
  output aos_out_t          out_r
);

  localparam int unsigned CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int unsigned DIFF_W  = (FRAME_BITS > REFR_W) ? FRAME_BITS : REFR_W;
  localparam int unsigned PTS_X_W = (CNT_W > POINTS_W) ? CNT_W : POINTS_W;
  localparam int unsigned FRM_X_W = (FRAME_BITS > FRAME_OUT_W) ? FRAME_BITS : FRAME_OUT_W;

  logic                  was_above_r, was_above_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [FRAME_BITS-1:0] last_r, last_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  ovf_r, ovf_nxt;

  logic                  was_eff, ovf_eff;
  logic [FRAME_BITS-1:0] frame_eff, last_eff;
  logic [CNT_W-1:0]      cnt_eff;
  logic [DIFF_W-1:0]     gap;
  logic                  spaced, trigger, full, onset;
  logic [PTS_X_W-1:0]    pts_x;
  logic [FRM_X_W-1:0]    frm_x;
  aos_out_t              out_nxt;

  always_comb begin
    // a first frame starts from cleared state
    was_eff   = step.first_frame ? 1'b0 : was_above_r;
    ovf_eff   = step.first_frame ? 1'b0 : ovf_r;
    frame_eff = step.first_frame ? '0 : frame_r;
    last_eff  = step.first_frame ? '0 : last_r;
    cnt_eff   = step.first_frame ? '0 : cnt_r;

    // last onset never lies ahead of the current frame
    gap     = DIFF_W'(frame_eff - last_eff);
    spaced  = (cnt_eff == '0) || (gap >= DIFF_W'(refractory));
    trigger = above && !was_eff && !ovf_eff && spaced;
    full    = (cnt_eff >= CNT_W'(MAX_POINTS));
    onset   = trigger && !full;

    ovf_nxt       = ovf_eff | (trigger & full);
    cnt_nxt       = onset ? cnt_eff + 1'b1 : cnt_eff;
    last_nxt      = onset ? frame_eff : last_eff;
    was_above_nxt = above;
    frame_nxt     = (&frame_eff) ? frame_eff : frame_eff + 1'b1;

    pts_x = PTS_X_W'(cnt_nxt);
    frm_x = FRM_X_W'(frame_eff);
    out_nxt.onset         = onset;
    out_nxt.onset_frame   = frm_x[FRAME_OUT_W-1:0];
    out_nxt.points_so_far = pts_x[POINTS_W-1:0];
    out_nxt.overflow      = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_above_r <= 1'b0;
      frame_r     <= '0;
      last_r      <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
    end else if (step.load) begin
      was_above_r <= was_above_nxt;
      frame_r     <= frame_nxt;
      last_r      <= last_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step.load) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for audio_onset_slicer_core. A scripted list of frames
// and register writes feeds the input channel in random bursts; every accepted
// frame runs through a cycle-free onset tracker kept here, and each result
// beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import aos_pkg::*;

  localparam int unsigned ONSET_LIMIT   = 4096;
  localparam int unsigned FULL_SCALE    = 32768;
  localparam int unsigned SETTLE_CYCLES = 4;     // idle cycles before a write
  localparam int unsigned TAIL_CYCLES   = 8;
  localparam int unsigned HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int unsigned STUCK_LIMIT   = 2000;  // cycles with no beat at all

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;  // not a register
  localparam logic [MAG_W-1:0]     PCM_SPAN      = 17'h10000;
  localparam logic [SAMPLE_W-1:0]  PCM_MIN       = 16'h8000;
  localparam logic [SAMPLE_W-1:0]  PCM_MAX       = 16'h7FFF;

  typedef enum logic [1:0] {ACT_FRAME, ACT_WRITE, ACT_PAUSE} plan_kind_t;
  typedef enum logic [1:0] {SHAPE_QUIET, SHAPE_LOUD, SHAPE_NOISE} frame_shape_t;
  typedef enum logic [1:0] {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_TOGGLE} flow_mode_t;

  typedef struct {
    plan_kind_t            kind;
    aos_in_t               beat;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] wdata;
  } plan_step_t;

  typedef struct packed {
    logic [THR_W-1:0]  thr;
    logic [REFR_W-1:0] refr;
    logic [CHAN_W-1:0] chan;
  } slicer_cfg_t;

  localparam slicer_cfg_t CFG_DEFAULT = {THRESHOLD_RST, REFRACTORY_RST, CHANNELS_RST};

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  aos_in_t               in_beat   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  aos_out_t              out_beat;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  plan_step_t  frame_plan[$];   // frames and writes still to be sent
  aos_out_t    marks_due[$];    // predicted result beats, oldest first
  int unsigned bad_beats = 0;

  // onset tracker state, mirrored from the block
  slicer_cfg_t            model_cfg;
  slicer_cfg_t            plan_cfg;   // register values as the script sees them
  logic                   was_loud;
  logic                   limit_hit;
  logic [FRAME_OUT_W-1:0] frame_idx;
  logic [FRAME_OUT_W-1:0] last_mark;
  logic [POINTS_W-1:0]    marks_made;

  audio_onset_slicer_core #(
    .MAX_CHANNELS (LANES_MAX),
    .MAX_POINTS   (ONSET_LIMIT),
    .FRAME_BITS   (FRAME_OUT_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // helpers shared by the script and the tracker
  // --------------------------------------------------------------------------

  function automatic slicer_cfg_t cfg_after_write(slicer_cfg_t c,
                                                  logic [CFG_IDX_W-1:0] idx,
                                                  logic [CFG_DATA_W-1:0] d);
    slicer_cfg_t r;
    r = c;
    case (idx)
      CFG_IDX_THRESHOLD:  r.thr  = d[THR_W-1:0];
      CFG_IDX_REFRACTORY: r.refr = d[REFR_W-1:0];
      CFG_IDX_CHANNELS:   r.chan = d[CHAN_W-1:0];
      default: ;  // spare index: write is dropped
    endcase
    return r;
  endfunction

  // zero channels means one, anything past the lane count means all lanes
  function automatic int unsigned lanes_used(logic [CHAN_W-1:0] chan);
    if (chan == 0) return 1;
    if (chan > LANES_MAX) return LANES_MAX;
    return chan;
  endfunction

  // sample_0 sits just below first_frame in the packed beat
  function automatic logic [SAMPLE_W-1:0] lane_of(aos_in_t b, int unsigned c);
    logic [$bits(aos_in_t)-1:0] raw;
    raw = b;
    return raw[(LANES_MAX-1-c)*SAMPLE_W +: SAMPLE_W];
  endfunction

  function automatic aos_in_t with_lane(aos_in_t b, int unsigned c,
                                        logic [SAMPLE_W-1:0] v);
    logic [$bits(aos_in_t)-1:0] raw;
    raw = b;
    raw[(LANES_MAX-1-c)*SAMPLE_W +: SAMPLE_W] = v;
    return raw;
  endfunction

  function automatic void clear_clip();
    was_loud   = 1'b0;
    limit_hit  = 1'b0;
    frame_idx  = '0;
    last_mark  = '0;
    marks_made = '0;
  endfunction

  // --------------------------------------------------------------------------
  // onset tracker: one frame in, the expected result beat out
  // --------------------------------------------------------------------------
  function automatic aos_out_t track_frame(aos_in_t b);
    aos_out_t               r;
    logic [SAMPLE_W-1:0]    s;
    logic [MAG_W-1:0]       mag;
    logic [MAG_W-1:0]       peak;
    logic [FRAME_OUT_W-1:0] now;
    logic                   loud;
    logic                   mark;
    int unsigned            c;
    if (b.first_frame) clear_clip();
    peak = '0;
    for (c = 0; c < lanes_used(model_cfg.chan); c++) begin
      s   = lane_of(b, c);
      mag = s[SAMPLE_W-1] ? PCM_SPAN - {1'b0, s} : {1'b0, s};
      if (mag > peak) peak = mag;
    end
    now  = frame_idx;
    loud = (peak >= model_cfg.thr);
    mark = 1'b0;
    // rising edge, not locked out, and first onset or refractory run out
    if (loud && !was_loud && !limit_hit &&
        (marks_made == 0 || now - last_mark >= model_cfg.refr)) begin
      if (marks_made >= ONSET_LIMIT) begin
        limit_hit = 1'b1;
      end else begin
        mark       = 1'b1;
        marks_made = marks_made + 1'b1;
        last_mark  = now;
      end
    end
    was_loud = loud;  // follows every frame, refused onsets too
    if (frame_idx != '1) frame_idx = frame_idx + 1'b1;
    r.onset         = mark;
    r.onset_frame   = now;
    r.points_so_far = marks_made;
    r.overflow      = limit_hit;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // script building
  // --------------------------------------------------------------------------

  // random sign; a magnitude of full scale always comes out as the minimum code
  function automatic logic [SAMPLE_W-1:0] pcm_of(int unsigned mag);
    logic [MAG_W-1:0] m;
    m = MAG_W'(mag);
    if ($urandom_range(0, 1) == 1) m = PCM_SPAN - m;
    return m[SAMPLE_W-1:0];
  endfunction

  // quiet: every lane in use below threshold; loud: one of them at or above.
  // lanes outside the used count stay fully random.
  function automatic aos_in_t frame_draw(frame_shape_t shape);
    logic [159:0] noise;
    aos_in_t      b;
    int unsigned  n;
    int unsigned  c;
    noise = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    b = noise[$bits(aos_in_t)-1:0];
    b.first_frame = 1'b0;
    n = lanes_used(plan_cfg.chan);
    if (shape != SHAPE_NOISE) begin
      if (plan_cfg.thr != 0) begin
        for (c = 0; c < n; c++)
          b = with_lane(b, c, pcm_of($urandom_range(0, plan_cfg.thr - 1)));
      end
      if (shape == SHAPE_LOUD)
        b = with_lane(b, $urandom_range(0, n - 1),
                      pcm_of($urandom_range(plan_cfg.thr, FULL_SCALE)));
    end
    return b;
  endfunction

  task automatic plan_frame(aos_in_t b);
    plan_step_t p;
    p.kind    = ACT_FRAME;
    p.beat    = b;
    p.reg_idx = '0;
    p.wdata   = '0;
    frame_plan.insert(frame_plan.size(), p);
  endtask

  task automatic plan_ctl(plan_kind_t kind, logic [CFG_IDX_W-1:0] idx,
                          logic [CFG_DATA_W-1:0] d);
    plan_step_t p;
    p.kind    = kind;
    p.beat    = '0;
    p.reg_idx = idx;
    p.wdata   = d;
    frame_plan.insert(frame_plan.size(), p);
    if (kind == ACT_WRITE) plan_cfg = cfg_after_write(plan_cfg, idx, d);
  endtask

  task automatic plan_lanes(bit first, logic [SAMPLE_W-1:0] s0, s1, s2, s3,
                            s4, s5, s6, s7);
    aos_in_t b;
    b.first_frame = first;
    b.sample_0 = s0;
    b.sample_1 = s1;
    b.sample_2 = s2;
    b.sample_3 = s3;
    b.sample_4 = s4;
    b.sample_5 = s5;
    b.sample_6 = s6;
    b.sample_7 = s7;
    plan_frame(b);
  endtask

  // one random register setting, then a clip of runs, each randomly loud or quiet
  task automatic plan_session(int unsigned frames);
    logic [CFG_DATA_W-1:0] d;
    int unsigned           n;
    int unsigned           pick;
    bit                    loud;
    bit                    fresh;
    frame_shape_t          shape;
    aos_in_t               b;
    d = CFG_DATA_W'($urandom());  // spare upper bits must be dropped by the block
    case ($urandom_range(0, 5))
      0:       d[THR_W-1:0] = '0;
      1:       d[THR_W-1:0] = THR_W'(1);
      2:       d[THR_W-1:0] = '1;
      3:       d[THR_W-1:0] = THR_W'($urandom_range(1, 300));
      default: d[THR_W-1:0] = THR_W'($urandom_range(1, 32767));
    endcase
    plan_ctl(ACT_WRITE, CFG_IDX_THRESHOLD, d);
    case ($urandom_range(0, 5))
      0:       d = '0;
      1:       d = CFG_DATA_W'(1);
      2:       d = '1;
      3:       d = CFG_DATA_W'($urandom_range(2, 40));
      default: d = CFG_DATA_W'($urandom_range(1, 12));
    endcase
    plan_ctl(ACT_WRITE, CFG_IDX_REFRACTORY, d);
    d = CFG_DATA_W'($urandom());
    if ($urandom_range(0, 3) == 0) d[CHAN_W-1:0] = CHAN_W'($urandom_range(0, 15));
    else d[CHAN_W-1:0] = CHAN_W'($urandom_range(1, LANES_MAX));
    plan_ctl(ACT_WRITE, CFG_IDX_CHANNELS, d);
    if ($urandom_range(0, 3) == 0)
      plan_ctl(ACT_WRITE, CFG_IDX_SPARE, CFG_DATA_W'($urandom()));

    fresh = ($urandom_range(0, 3) != 0);  // else the clip carries on
    n = 0;
    while (n < frames) begin
      loud = 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 6)) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) shape = SHAPE_NOISE;
        else if (loud) shape = SHAPE_LOUD;
        else shape = SHAPE_QUIET;
        b = frame_draw(shape);
        b.first_frame = (n == 0) ? fresh : (pick == 99);
        plan_frame(b);
        n++;
        if (pick == 98) plan_ctl(ACT_PAUSE, CFG_IDX_SPARE, '0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // input driver: walks the script; frames go out in bursts, writes and
  // pauses wait until every predicted beat has come back
  // --------------------------------------------------------------------------
  int unsigned gap_left;
  int unsigned burst_left;
  int unsigned settle_left;

  always @(posedge clk) begin : feed
    logic                  nxt_valid;
    logic                  nxt_we;
    aos_in_t               nxt_beat;
    logic [CFG_IDX_W-1:0]  nxt_idx;
    logic [CFG_DATA_W-1:0] nxt_wdata;
    nxt_valid = in_valid;
    nxt_beat  = in_beat;
    nxt_we    = 1'b0;
    nxt_idx   = cfg_index;
    nxt_wdata = cfg_wdata;
    if (!rst_n) begin
      nxt_valid   = 1'b0;
      model_cfg   = CFG_DEFAULT;
      clear_clip();
      gap_left    = 0;
      burst_left  = $urandom_range(1, 40);
      settle_left = SETTLE_CYCLES;
    end else begin
      if (in_valid && !in_stall) begin
        marks_due.insert(marks_due.size(), track_frame(in_beat));
        void'(frame_plan.pop_front());
        nxt_valid = 1'b0;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // now and then a long unbroken stretch
          burst_left = ($urandom_range(0, 7) == 0) ? 400 : $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (!nxt_valid && frame_plan.size() != 0) begin
        if (frame_plan[0].kind == ACT_FRAME) begin
          if (gap_left != 0) begin
            gap_left--;
          end else begin
            nxt_valid = 1'b1;
            nxt_beat  = frame_plan[0].beat;
          end
        end else if (marks_due.size() != 0) begin
          settle_left = SETTLE_CYCLES;
        end else if (settle_left != 0) begin
          settle_left--;
        end else begin
          if (frame_plan[0].kind == ACT_WRITE) begin
            nxt_we    = 1'b1;
            nxt_idx   = frame_plan[0].reg_idx;
            nxt_wdata = frame_plan[0].wdata;
            model_cfg = cfg_after_write(model_cfg, nxt_idx, nxt_wdata);
          end
          void'(frame_plan.pop_front());
          settle_left = SETTLE_CYCLES;
        end
      end
    end
    in_valid  <= nxt_valid;
    in_beat   <= nxt_beat;
    cfg_we    <= nxt_we;
    cfg_index <= nxt_idx;
    cfg_wdata <= nxt_wdata;
  end

  // --------------------------------------------------------------------------
  // result side stall: changing random patterns, plus long hold-offs every
  // few thousand beats so both stages fill and in_stall rises
  // --------------------------------------------------------------------------
  flow_mode_t  flow_mode;
  int unsigned flow_left;
  int unsigned hold_left;
  int unsigned next_hold;
  int unsigned results_taken;

  always @(posedge clk) begin : sink
    logic nxt_stall;
    nxt_stall = 1'b0;
    if (!rst_n) begin
      flow_mode     = FLOW_FREE;
      flow_left     = 100;
      hold_left     = 0;
      next_hold     = 300;
      results_taken = 0;
    end else begin
      if (out_valid && !out_stall) results_taken++;
      if (results_taken >= next_hold) begin
        hold_left = HOLD_CYCLES;
        next_hold = next_hold + 2700;
      end
      if (flow_left == 0) begin
        flow_mode = flow_mode_t'($urandom_range(0, 3));
        flow_left = $urandom_range(16, 256);
      end else begin
        flow_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        nxt_stall = 1'b1;
      end else begin
        case (flow_mode)
          FLOW_LIGHT:  nxt_stall = ($urandom_range(0, 3) == 0);
          FLOW_HEAVY:  nxt_stall = ($urandom_range(0, 3) != 0);
          FLOW_TOGGLE: nxt_stall = !out_stall;
          default:     nxt_stall = 1'b0;
        endcase
      end
    end
    out_stall <= nxt_stall;
  end

  // --------------------------------------------------------------------------
  // result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : observe
    aos_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (marks_due.size() == 0) begin
        $error("result beat with no frame pending");
        bad_beats++;
      end else begin
        want = marks_due.pop_front();
        if (out_beat.onset !== want.onset) begin
          $error("onset: expected %0d, got %0d", want.onset, out_beat.onset);
          bad_beats++;
        end
        if (out_beat.onset_frame !== want.onset_frame) begin
          $error("onset_frame: expected %0d, got %0d",
                 want.onset_frame, out_beat.onset_frame);
          bad_beats++;
        end
        if (out_beat.points_so_far !== want.points_so_far) begin
          $error("points_so_far: expected %0d, got %0d",
                 want.points_so_far, out_beat.points_so_far);
          bad_beats++;
        end
        if (out_beat.overflow !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, out_beat.overflow);
          bad_beats++;
        end
      end
    end
  end

  // any beat on any port counts as progress
  int unsigned stuck_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // scenario
  // --------------------------------------------------------------------------
  initial begin : scenario
    plan_cfg = CFG_DEFAULT;

    // reset settings: threshold 4096, refractory 240, two lanes
    plan_lanes(1, 0, 0, 0, 0, 0, 0, 0, 0);
    plan_lanes(0, PCM_MIN, 0, 0, 0, 0, 0, 0, 0);           // -32768 is loudest
    plan_lanes(0, 0, PCM_MAX, 0, 0, 0, 0, 0, 0);           // still loud, no edge
    plan_lanes(0, 4095, -16'sd4095, PCM_MIN, PCM_MIN, PCM_MIN, PCM_MIN,
               PCM_MIN, PCM_MIN);                          // unused lanes ignored
    plan_lanes(0, 0, -16'sd4096, 0, 0, 0, 0, 0, 0);        // edge inside refractory
    plan_lanes(0, 4095, 0, 0, 0, 0, 0, 0, 0);

    // threshold zero (upper data bits set), refractory zero, channel count zero
    plan_ctl(ACT_WRITE, CFG_IDX_THRESHOLD, 20'hF8000);
    plan_ctl(ACT_WRITE, CFG_IDX_REFRACTORY, 20'h00000);
    plan_ctl(ACT_WRITE, CFG_IDX_CHANNELS, 20'h00000);
    plan_ctl(ACT_WRITE, CFG_IDX_SPARE, 20'hFFFFF);
    plan_lanes(0, 0, 0, 0, 0, 0, 0, 0, 0);                 // silence counts as loud
    plan_lanes(0, 0, 0, 0, 0, 0, 0, 0, 0);

    // top threshold, longest refractory, channel count past the lane count
    plan_ctl(ACT_WRITE, CFG_IDX_THRESHOLD, 20'h07FFF);
    plan_ctl(ACT_WRITE, CFG_IDX_REFRACTORY, 20'hFFFFF);
    plan_ctl(ACT_WRITE, CFG_IDX_CHANNELS, 20'hFFFFF);
    plan_lanes(1, 0, 0, 0, 0, 0, 0, 0, PCM_MIN);
    plan_lanes(0, 0, 0, 0, 0, 0, 0, 0, PCM_MAX);
    plan_lanes(0, 0, 0, 0, 0, 0, 0, 0, -16'sd32767);
    plan_lanes(0, 32766, -16'sd32766, 32766, -16'sd32766, 32766, -16'sd32766,
               32766, -16'sd32766);
    plan_lanes(0, 0, 0, 0, PCM_MAX, 0, 0, 0, 0);           // refused by refractory
    plan_lanes(1, PCM_MAX, 0, 0, 0, 0, 0, 0, 0);           // new clip while loud

    // single lane, threshold one, refractory one
    plan_ctl(ACT_WRITE, CFG_IDX_CHANNELS, 20'd1);
    plan_ctl(ACT_WRITE, CFG_IDX_THRESHOLD, 20'd1);
    plan_ctl(ACT_WRITE, CFG_IDX_REFRACTORY, 20'd1);
    plan_lanes(1, 0, PCM_MIN, 0, 0, 0, 0, 0, 0);
    plan_lanes(0, 1, 0, 0, 0, 0, 0, 0, 0);
    plan_lanes(0, 0, PCM_MAX, 0, 0, 0, 0, 0, 0);
    plan_lanes(0, -16'sd1, 0, 0, 0, 0, 0, 0, 0);

    repeat (12) plan_session(140);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (frame_plan.size() != 0 || marks_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_beats == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
